/* rtl/cwm_pkg.sv */
// Shared types and codes for the completion waiter matcher.
`timescale 1ns / 1ps
package cwm_pkg;

    localparam logic [2:0] OP_REG_QUEUE   = 3'd0;
    localparam logic [2:0] OP_UNREG_QUEUE = 3'd1;
    localparam logic [2:0] OP_SUBMIT      = 3'd2;
    localparam logic [2:0] OP_COMPLETION  = 3'd3;
    localparam logic [2:0] OP_TAKE        = 3'd4;
    localparam logic [2:0] OP_REMATCH     = 3'd5;
    localparam logic [2:0] OP_COMPACT     = 3'd6;
    localparam logic [2:0] OP_CANCEL      = 3'd7;

    localparam logic [3:0] OC_OK        = 4'd0;
    localparam logic [3:0] OC_FULL      = 4'd1;
    localparam logic [3:0] OC_DONE      = 4'd2;
    localparam logic [3:0] OC_FAILED    = 4'd3;
    localparam logic [3:0] OC_STASHED   = 4'd4;
    localparam logic [3:0] OC_DROPPED   = 4'd5;
    localparam logic [3:0] OC_HIT       = 4'd6;
    localparam logic [3:0] OC_MISS      = 4'd7;
    localparam logic [3:0] OC_FAULTED   = 4'd8;
    localparam logic [3:0] OC_NOT_FOUND = 4'd9;

    // One waiter entry as held in a cell.
    typedef struct packed {
        logic        valid;
        logic [63:0] wr_id;
        logic [15:0] cq_id;
        logic [15:0] tag;
    } t_waiter;

    // One stashed completion.
    typedef struct packed {
        logic [63:0] wr_id;
        logic [15:0] cq_id;
        logic [31:0] info;
    } t_stash;

    // Per-cell command from the controller to the waiter row.
    typedef struct packed {
        logic        append;   // write new entry at fill position
        logic        clear;    // clear valid in the selected slot
        logic        shift;    // compaction step: move one slot down
    } t_wcmd;

endpackage

/* rtl/completion_waiter_matcher.sv */
// Top level of the completion waiter matcher: controller, stash and cell row.
`timescale 1ns / 1ps
// Each beat takes one operation and returns one or more result beats, the
// final one marked by o_last. The waiter table is a row of cells that
// compare every slot against the request at once. A simple operation is
// captured in the input registers and its result is registered in the
// output register; o_stall holds off the next beat until the controller is
// idle again. A stash overflow walks the waiter slots to the last failing
// waiter to emit failures in slot order. Rematch tests each stash entry in
// turn, then gives a closing result. Compact walks the waiter slots below
// the fill, then gives a closing result, as the row shifts entries down. A
// stalled result holds the controller. One item is worked on at a time.
module completion_waiter_matcher #(
    parameter int WAITER_SLOTS = 32,
    parameter int STASH_SLOTS  = 16,
    parameter int QUEUE_SLOTS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_cq_id,
    input  logic [63:0] i_wr_id,
    input  logic [15:0] i_waiter_tag,
    input  logic [31:0] i_completion_info,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_outcome,
    output logic [15:0] o_out_waiter_tag,
    output logic [63:0] o_out_wr_id,
    output logic [31:0] o_out_completion,
    output logic [31:0] o_overflow_count,
    output logic        o_last
);
    localparam int WW = $clog2(WAITER_SLOTS);
    localparam int SW = $clog2(STASH_SLOTS);
    localparam int QW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int WF = $clog2(WAITER_SLOTS + 1);
    localparam int SF = $clog2(STASH_SLOTS + 1);
    localparam int QF = $clog2(QUEUE_SLOTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_FAIL  = 3'd2;
    localparam logic [2:0] S_REM   = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_REMW  = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_op;
    logic [15:0] r_q, r_tag, r_key_q;
    logic [63:0] r_wr, r_key_wr;
    logic [31:0] r_info;

    logic [WF-1:0] r_wfill;
    logic [SF-1:0] r_sfill;
    logic [QF-1:0] r_qfill;
    logic [31:0]   r_ovf;
    logic [WF-1:0] r_idx;   // walk index (waiter slot or dst)
    logic [SF-1:0] r_sidx;  // rematch source index
    logic [SF-1:0] r_sdst;

    logic [15:0] r_qtab [QUEUE_SLOTS];
    logic [QUEUE_SLOTS-1:0] r_qen, r_qflt;
    cwm_pkg::t_stash r_stash [STASH_SLOTS];

    // output register
    logic        r_ov;
    logic [3:0]  r_oc;
    logic [15:0] r_otag;
    logic [63:0] r_owr;
    logic [31:0] r_ocomp;
    logic        r_olast;

    // cell row
    cwm_pkg::t_waiter w_ent [WAITER_SLOTS];
    logic [WAITER_SLOTS-1:0] w_match, w_qmatch, w_cmatch;
    logic [WAITER_SLOTS-1:0] c_wr, c_clr, c_take;
    cwm_pkg::t_waiter c_wdata;

    genvar g;
    generate
        for (g = 0; g < WAITER_SLOTS; g++) begin : g_cell
            cwm_pkg::t_waiter w_nx;
            if (g == WAITER_SLOTS - 1) begin : g_end
                assign w_nx = '0;
            end else begin : g_mid
                assign w_nx = w_ent[g+1];
            end
            cwm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wr    (c_wr[g]),
                .i_wdata (c_wdata),
                .i_clr   (c_clr[g]),
                .i_take  (c_take[g]),
                .i_next  (w_nx),
                .i_cq_id (r_key_q),
                .i_wr_id (r_key_wr),
                .i_tag   (r_tag),
                .o_entry (w_ent[g]),
                .o_match (w_match[g]),
                .o_qmatch(w_qmatch[g]),
                .o_cmatch(w_cmatch[g])
            );
        end
    endgenerate

    // newest match (highest index) and oldest cancel match
    logic          w_nhit, w_chit;
    logic [WW-1:0] w_nidx, w_cidx;
    always_comb begin
        w_nhit = 1'b0;
        w_nidx = '0;
        for (int j = 0; j < WAITER_SLOTS; j++) begin
            if (w_match[j]) begin
                w_nhit = 1'b1;
                w_nidx = WW'(j);
            end
        end
        w_chit = 1'b0;
        w_cidx = '0;
        for (int j = WAITER_SLOTS - 1; j >= 0; j--) begin
            if (w_cmatch[j]) begin
                w_chit = 1'b1;
                w_cidx = WW'(j);
            end
        end
    end

    // first queue entry with this id
    logic          q_hit;
    logic [QW-1:0] q_idx;
    always_comb begin
        q_hit = 1'b0;
        q_idx = '0;
        for (int j = QUEUE_SLOTS - 1; j >= 0; j--) begin
            if (QF'(j) < r_qfill && r_qtab[j] == r_q) begin
                q_hit = 1'b1;
                q_idx = QW'(j);
            end
        end
    end

    // first stash match (lowest index)
    logic          s_hit;
    logic [SW-1:0] s_idx;
    always_comb begin
        s_hit = 1'b0;
        s_idx = '0;
        for (int j = STASH_SLOTS - 1; j >= 0; j--) begin
            if (SF'(j) < r_sfill && r_stash[j].cq_id == r_q && r_stash[j].wr_id == r_wr) begin
                s_hit = 1'b1;
                s_idx = SW'(j);
            end
        end
    end

    logic out_free;
    assign out_free = !r_ov || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    logic [SW-1:0] w_sidx, w_slast;
    logic [WW-1:0] w_idx;
    assign w_sidx  = r_sidx[SW-1:0];
    assign w_slast = SW'(r_sfill - SF'(1));
    assign w_idx   = r_idx[WW-1:0];

    logic          emit;
    logic [3:0]    e_oc;
    logic [15:0]   e_tag;
    logic [63:0]   e_wr;
    logic [31:0]   e_comp;
    logic          e_last;

    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        e_oc    = cwm_pkg::OC_OK;
        e_tag   = '0;
        e_wr    = '0;
        e_comp  = '0;
        e_last  = 1'b1;
        c_wr    = '0;
        c_clr   = '0;
        c_take  = '0;
        c_wdata = '{valid: 1'b1, wr_id: r_wr, cq_id: r_q, tag: r_tag};
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    case (r_op)
                        cwm_pkg::OP_REG_QUEUE: begin
                            e_oc = (r_qfill >= QF'(QUEUE_SLOTS)) ? cwm_pkg::OC_FULL
                                                                 : cwm_pkg::OC_OK;
                        end
                        cwm_pkg::OP_UNREG_QUEUE: begin
                            e_oc = q_hit ? cwm_pkg::OC_OK : cwm_pkg::OC_NOT_FOUND;
                        end
                        cwm_pkg::OP_SUBMIT: begin
                            e_tag = r_tag;
                            e_wr  = r_wr;
                            if (r_wfill >= WF'(WAITER_SLOTS)) begin
                                e_oc = cwm_pkg::OC_FULL;
                            end else begin
                                c_wr[r_wfill[WW-1:0]] = 1'b1;
                            end
                        end
                        cwm_pkg::OP_COMPLETION: begin
                            e_wr = r_wr;
                            e_comp = r_info;
                            if (w_nhit) begin
                                e_oc  = cwm_pkg::OC_DONE;
                                e_tag = w_ent[w_nidx].tag;
                                c_clr[w_nidx] = 1'b1;
                            end else if (r_sfill < SF'(STASH_SLOTS)) begin
                                e_oc = cwm_pkg::OC_STASHED;
                            end else begin
                                e_oc    = cwm_pkg::OC_DROPPED;
                                e_last  = (w_qmatch == '0);
                                n_state = e_last ? S_IDLE : S_FAIL;
                            end
                        end
                        cwm_pkg::OP_TAKE: begin
                            e_wr = r_wr;
                            if (q_hit && r_qflt[q_idx]) begin
                                e_oc = cwm_pkg::OC_FAULTED;
                            end else if (s_hit) begin
                                e_oc   = cwm_pkg::OC_HIT;
                                e_comp = r_stash[s_idx].info;
                            end else begin
                                e_oc = cwm_pkg::OC_MISS;
                            end
                        end
                        cwm_pkg::OP_REMATCH: begin
                            emit    = 1'b0;
                            n_state = S_REM;
                        end
                        cwm_pkg::OP_COMPACT: begin
                            emit    = 1'b0;
                            n_state = S_CMP;
                        end
                        cwm_pkg::OP_CANCEL: begin
                            e_wr = r_wr;
                            if (w_chit) begin
                                e_tag = r_tag;
                                c_clr[w_cidx] = 1'b1;
                            end else begin
                                e_oc = cwm_pkg::OC_NOT_FOUND;
                            end
                        end
                        default: begin
                            e_oc = cwm_pkg::OC_OK;
                        end
                    endcase
                end
            end
            S_FAIL: begin
                // walk slots in ascending order, fail each active one on the queue
                if (w_qmatch[w_idx]) begin
                    if (out_free) begin
                        emit   = 1'b1;
                        e_oc   = cwm_pkg::OC_FAILED;
                        e_tag  = w_ent[w_idx].tag;
                        e_wr   = w_ent[w_idx].wr_id;
                        c_clr[w_idx] = 1'b1;
                        e_last = ((w_qmatch & ~(WAITER_SLOTS'(1) << w_idx)) == '0);
                        if (e_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_REM: begin
                if (r_sidx >= r_sfill) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_REMW;
                end
            end
            S_REMW: begin
                // key registers now hold the stash entry under test
                if (w_nhit) begin
                    if (out_free) begin
                        emit   = 1'b1;
                        e_oc   = cwm_pkg::OC_DONE;
                        e_tag  = w_ent[w_nidx].tag;
                        e_wr   = r_stash[w_sidx].wr_id;
                        e_comp = r_stash[w_sidx].info;
                        e_last = 1'b0;
                        c_clr[w_nidx] = 1'b1;
                        n_state = S_REM;
                    end
                end else begin
                    n_state = S_REM;
                end
            end
            S_CMP: begin
                // drop the first inactive slot below fill by shifting the row down
                if (r_idx >= r_wfill) begin
                    n_state = S_OUT;
                end else if (!w_ent[w_idx].valid) begin
                    for (int j = 0; j < WAITER_SLOTS; j++) begin
                        c_take[j] = (WW'(j) >= w_idx);
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op     <= i_operation;
            r_q      <= i_cq_id;
            r_wr     <= i_wr_id;
            r_tag    <= i_waiter_tag;
            r_info   <= i_completion_info;
            r_key_q  <= i_cq_id;
            r_key_wr <= i_wr_id;
        end
        if (emit) begin
            r_oc    <= e_oc;
            r_otag  <= e_tag;
            r_owr   <= e_wr;
            r_ocomp <= e_comp;
            r_olast <= e_last;
        end
        if (r_state == S_REM && r_sidx < r_sfill) begin
            r_key_q  <= r_stash[w_sidx].cq_id;
            r_key_wr <= r_stash[w_sidx].wr_id;
        end
        if (r_state == S_EXEC && emit) begin
            case (r_op)
                cwm_pkg::OP_REG_QUEUE: begin
                    if (r_qfill < QF'(QUEUE_SLOTS)) begin
                        r_qtab[r_qfill[QW-1:0]] <= r_q;
                    end
                end
                cwm_pkg::OP_COMPLETION: begin
                    if (!w_nhit && r_sfill < SF'(STASH_SLOTS)) begin
                        r_stash[r_sfill[SW-1:0]] <= '{wr_id: r_wr, cq_id: r_q, info: r_info};
                    end
                end
                cwm_pkg::OP_TAKE: begin
                    if (!(q_hit && r_qflt[q_idx]) && s_hit) begin
                        r_stash[s_idx] <= r_stash[w_slast];
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_state == S_REMW && !w_nhit) begin
            // keep the entry, packed toward the front
            r_stash[r_sdst[SW-1:0]] <= r_stash[w_sidx];
        end

        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_wfill <= '0;
            r_sfill <= '0;
            r_qfill <= '0;
            r_ovf   <= '0;
            r_qen   <= '0;
            r_qflt  <= '0;
            r_idx   <= '0;
            r_sidx  <= '0;
            r_sdst  <= '0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_IDLE) begin
                r_idx  <= '0;
                r_sidx <= '0;
                r_sdst <= '0;
            end
            if (r_state == S_EXEC && emit) begin
                case (r_op)
                    cwm_pkg::OP_REG_QUEUE: begin
                        if (r_qfill < QF'(QUEUE_SLOTS)) begin
                            r_qen[r_qfill[QW-1:0]]  <= 1'b1;
                            r_qflt[r_qfill[QW-1:0]] <= 1'b0;
                            r_qfill <= r_qfill + QF'(1);
                        end
                    end
                    cwm_pkg::OP_UNREG_QUEUE: begin
                        if (q_hit) begin
                            r_qen[q_idx] <= 1'b0;
                        end
                    end
                    cwm_pkg::OP_SUBMIT: begin
                        if (r_wfill < WF'(WAITER_SLOTS)) begin
                            r_wfill <= r_wfill + WF'(1);
                        end
                    end
                    cwm_pkg::OP_COMPLETION: begin
                        if (!w_nhit) begin
                            if (r_sfill < SF'(STASH_SLOTS)) begin
                                r_sfill <= r_sfill + SF'(1);
                            end else begin
                                if (r_ovf != '1) begin
                                    r_ovf <= r_ovf + 32'd1;
                                end
                                if (q_hit) begin
                                    r_qflt[q_idx] <= 1'b1;
                                end
                            end
                        end
                    end
                    cwm_pkg::OP_TAKE: begin
                        if (!(q_hit && r_qflt[q_idx]) && s_hit) begin
                            r_sfill <= r_sfill - SF'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == S_FAIL && (!w_qmatch[w_idx] || out_free)) begin
                r_idx <= r_idx + WF'(1);
            end
            if (r_state == S_REMW && (!w_nhit || out_free)) begin
                r_sidx <= r_sidx + SF'(1);
                if (!w_nhit) begin
                    r_sdst <= r_sdst + SF'(1);
                end
            end
            if (r_state == S_REM && r_sidx >= r_sfill && r_op == cwm_pkg::OP_REMATCH) begin
                r_sfill <= r_sdst;
            end
            if (r_state == S_CMP && r_idx < r_wfill) begin
                if (w_ent[w_idx].valid) begin
                    r_idx <= r_idx + WF'(1);
                end else begin
                    r_wfill <= r_wfill - WF'(1);
                end
            end
        end
    end

    assign o_valid          = r_ov;
    assign o_outcome        = r_oc;
    assign o_out_waiter_tag = r_otag;
    assign o_out_wr_id      = r_owr;
    assign o_out_completion = r_ocomp;
    assign o_overflow_count = r_ovf;
    assign o_last           = r_olast;
endmodule

/* rtl/cwm_cell.sv */
// One waiter cell: holds an entry, compares it, and shifts during compaction.
`timescale 1ns / 1ps
module cwm_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  cwm_pkg::t_waiter i_wdata,
    input  logic            i_clr,
    input  logic            i_take,
    input  cwm_pkg::t_waiter i_next,
    input  logic [15:0]     i_cq_id,
    input  logic [63:0]     i_wr_id,
    input  logic [15:0]     i_tag,
    output cwm_pkg::t_waiter o_entry,
    output logic            o_match,
    output logic            o_qmatch,
    output logic            o_cmatch
);
    cwm_pkg::t_waiter r_entry;
    cwm_pkg::t_waiter n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_take) begin
            n_entry = i_next;
        end else if (i_wr) begin
            n_entry = i_wdata;
        end else if (i_clr) begin
            n_entry.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end
    end

    assign o_entry  = r_entry;
    assign o_qmatch = r_entry.valid && (r_entry.cq_id == i_cq_id);
    assign o_match  = o_qmatch && (r_entry.wr_id == i_wr_id);
    assign o_cmatch = o_match && (r_entry.tag == i_tag);
endmodule

/* test/testbench.sv */
// Self-checking testbench for the completion waiter matcher.
`timescale 1ns / 1ps
module testbench;

    localparam int WSLOTS = 32;
    localparam int SSLOTS = 16;
    localparam int QSLOTS = 8;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] cq;
        logic [63:0] wr;
        logic [15:0] tag;
        logic [31:0] info;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  outcome;
        logic [15:0] tag;
        logic [63:0] wr;
        logic [31:0] comp;
        logic [31:0] ovf;
        logic        last;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_operation;
    logic [15:0] i_cq_id;
    logic [63:0] i_wr_id;
    logic [15:0] i_waiter_tag;
    logic [31:0] i_completion_info;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_outcome;
    logic [15:0] o_out_waiter_tag;
    logic [63:0] o_out_wr_id;
    logic [31:0] o_out_completion;
    logic [31:0] o_overflow_count;
    logic        o_last;

    completion_waiter_matcher dut (.*);

    // matcher state mirror
    logic        w_act [WSLOTS];
    logic [63:0] w_wr [WSLOTS];
    logic [15:0] w_cq [WSLOTS];
    logic [15:0] w_tag [WSLOTS];
    int          w_fill;
    logic [63:0] s_wr [SSLOTS];
    logic [15:0] s_cq [SSLOTS];
    logic [31:0] s_info [SSLOTS];
    int          s_fill;
    logic [15:0] q_id [QSLOTS];
    logic        q_fault [QSLOTS];
    int          q_fill;
    logic [31:0] drop_count;

    t_cmd pending_cmds[$];
    t_res expected_beats[$];
    int   errors;
    bit   stim_done;
    bit   hold_send;
    bit   calm;
    int   send_gap;
    int   stall_gap;
    int   idle_cycles;

    function automatic int find_q(logic [15:0] q);
        for (int i = 0; i < q_fill; i++)
            if (q_id[i] == q) return i;
        return -1;
    endfunction

    function automatic int newest(logic [15:0] q, logic [63:0] wr);
        for (int j = w_fill - 1; j >= 0; j--)
            if (w_act[j] && w_cq[j] == q && w_wr[j] == wr) return j;
        return -1;
    endfunction

    function automatic void push_beat(logic [3:0] oc, logic [15:0] tag, logic [63:0] wr,
                                      logic [31:0] comp);
        t_res r;
        r = '{oc, tag, wr, comp, drop_count, 1'b0};
        expected_beats.push_back(r);
    endfunction

    function automatic void predict_match(t_cmd c);
        int k;
        int dst;
        bit hit;
        int before_n;
        t_res r;
        before_n = expected_beats.size();
        case (c.op)
            cwm_pkg::OP_REG_QUEUE: begin
                if (q_fill >= QSLOTS) begin
                    push_beat(cwm_pkg::OC_FULL, 0, 0, 0);
                end else begin
                    q_id[q_fill] = c.cq;
                    q_fault[q_fill] = 1'b0;
                    q_fill++;
                    push_beat(cwm_pkg::OC_OK, 0, 0, 0);
                end
            end
            cwm_pkg::OP_UNREG_QUEUE: begin
                // enable flag has no visible effect
                push_beat(find_q(c.cq) >= 0 ? cwm_pkg::OC_OK : cwm_pkg::OC_NOT_FOUND,
                          0, 0, 0);
            end
            cwm_pkg::OP_SUBMIT: begin
                if (w_fill >= WSLOTS) begin
                    push_beat(cwm_pkg::OC_FULL, c.tag, c.wr, 0);
                end else begin
                    w_act[w_fill] = 1'b1;
                    w_wr[w_fill] = c.wr;
                    w_cq[w_fill] = c.cq;
                    w_tag[w_fill] = c.tag;
                    w_fill++;
                    push_beat(cwm_pkg::OC_OK, c.tag, c.wr, 0);
                end
            end
            cwm_pkg::OP_COMPLETION: begin
                k = newest(c.cq, c.wr);
                if (k >= 0) begin
                    w_act[k] = 1'b0;
                    push_beat(cwm_pkg::OC_DONE, w_tag[k], c.wr, c.info);
                end else if (s_fill < SSLOTS) begin
                    s_wr[s_fill] = c.wr;
                    s_cq[s_fill] = c.cq;
                    s_info[s_fill] = c.info;
                    s_fill++;
                    push_beat(cwm_pkg::OC_STASHED, 0, c.wr, c.info);
                end else begin
                    if (drop_count != 32'hFFFF_FFFF) drop_count++;
                    k = find_q(c.cq);
                    if (k >= 0) q_fault[k] = 1'b1;
                    push_beat(cwm_pkg::OC_DROPPED, 0, c.wr, c.info);
                    for (int i = 0; i < w_fill; i++)
                        if (w_act[i] && w_cq[i] == c.cq) begin
                            w_act[i] = 1'b0;
                            push_beat(cwm_pkg::OC_FAILED, w_tag[i], w_wr[i], 0);
                        end
                end
            end
            cwm_pkg::OP_TAKE: begin
                k = find_q(c.cq);
                hit = 0;
                if (k >= 0 && q_fault[k]) begin
                    push_beat(cwm_pkg::OC_FAULTED, 0, c.wr, 0);
                    hit = 1;
                end else begin
                    for (int i = 0; i < s_fill && !hit; i++)
                        if (s_cq[i] == c.cq && s_wr[i] == c.wr) begin
                            push_beat(cwm_pkg::OC_HIT, 0, c.wr, s_info[i]);
                            s_fill--;
                            s_wr[i] = s_wr[s_fill];
                            s_cq[i] = s_cq[s_fill];
                            s_info[i] = s_info[s_fill];
                            hit = 1;
                        end
                end
                if (!hit) push_beat(cwm_pkg::OC_MISS, 0, c.wr, 0);
            end
            cwm_pkg::OP_REMATCH: begin
                dst = 0;
                for (int i = 0; i < s_fill; i++) begin
                    k = newest(s_cq[i], s_wr[i]);
                    if (k >= 0) begin
                        w_act[k] = 1'b0;
                        push_beat(cwm_pkg::OC_DONE, w_tag[k], s_wr[i], s_info[i]);
                    end else begin
                        s_wr[dst] = s_wr[i];
                        s_cq[dst] = s_cq[i];
                        s_info[dst] = s_info[i];
                        dst++;
                    end
                end
                s_fill = dst;
                push_beat(cwm_pkg::OC_OK, 0, 0, 0);
            end
            cwm_pkg::OP_COMPACT: begin
                dst = 0;
                for (int i = 0; i < w_fill; i++)
                    if (w_act[i]) begin
                        w_act[dst] = 1'b1;
                        w_wr[dst] = w_wr[i];
                        w_cq[dst] = w_cq[i];
                        w_tag[dst] = w_tag[i];
                        if (dst != i) w_act[i] = 1'b0;
                        dst++;
                    end
                w_fill = dst;
                push_beat(cwm_pkg::OC_OK, 0, 0, 0);
            end
            default: begin
                hit = 0;
                for (int i = 0; i < w_fill && !hit; i++)
                    if (w_act[i] && w_cq[i] == c.cq && w_wr[i] == c.wr && w_tag[i] == c.tag) begin
                        w_act[i] = 1'b0;
                        push_beat(cwm_pkg::OC_OK, c.tag, c.wr, 0);
                        hit = 1;
                    end
                if (!hit) push_beat(cwm_pkg::OC_NOT_FOUND, 0, c.wr, 0);
            end
        endcase
        r = expected_beats[$];
        r.last = 1'b1;
        expected_beats[$] = r;
    endfunction

    function automatic t_cmd make_cmd(logic [2:0] op, logic [15:0] cq, logic [63:0] wr,
                                      logic [15:0] tag, logic [31:0] info);
        t_cmd c;
        c = '{op, cq, wr, tag, info};
        return c;
    endfunction

    // random item: mostly drawn from a small id pool so completions meet waiters
    function automatic t_cmd rand_cmd();
        logic [15:0] cq;
        logic [63:0] wr;
        int pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) cq = 16'($urandom);
        else cq = 16'($urandom_range(0, 3)) | ($urandom_range(0, 1) ? 16'hFF00 : 16'h0);
        if ($urandom_range(0, 9) == 0) wr = {$urandom, $urandom};
        else wr = 64'($urandom_range(0, 5)) | ($urandom_range(0, 1) ? 64'hA5A5_0000_0000_0000 : 0);
        return make_cmd(pick < 6 ? cwm_pkg::OP_REG_QUEUE : pick < 10 ? cwm_pkg::OP_UNREG_QUEUE :
                        pick < 40 ? cwm_pkg::OP_SUBMIT : pick < 72 ? cwm_pkg::OP_COMPLETION :
                        pick < 82 ? cwm_pkg::OP_TAKE : pick < 88 ? cwm_pkg::OP_REMATCH :
                        pick < 93 ? cwm_pkg::OP_COMPACT : cwm_pkg::OP_CANCEL,
                        cq, wr, 16'($urandom_range(0, 3)) ^ 16'($urandom & 32'hFFF0),
                        $urandom);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        hold_send = 1'b1;
        calm = 1'b0;
        stim_done = 1'b0;
        w_fill = 0;
        s_fill = 0;
        q_fill = 0;
        drop_count = '0;
        errors = 0;
        // directed: queue table fill, extremes, stash overflow with failures
        for (int i = 0; i < QSLOTS; i++)
            pending_cmds.push_back(make_cmd(cwm_pkg::OP_REG_QUEUE,
                                            i == 0 ? 16'hFFFF : 16'(i), 0, 0, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_REG_QUEUE, 16'h7, 0, 0, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_UNREG_QUEUE, 16'hFFFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_UNREG_QUEUE, 16'h1234, 0, 0, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_SUBMIT, 16'hFFFF, '1, 16'hFFFF, '1));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_SUBMIT, 16'hFFFF, '1, 16'h0001, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_COMPLETION, 16'hFFFF, '1, 0, '1));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_CANCEL, 16'hFFFF, '1, 16'hFFFF, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_CANCEL, 16'hFFFF, '1, 16'hFFFF, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_COMPACT, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_TAKE, 16'h2, 64'h5, 0, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_REMATCH, 0, 0, 0, 0));
        for (int i = 0; i < SSLOTS; i++)
            pending_cmds.push_back(make_cmd(cwm_pkg::OP_COMPLETION, 16'h2, 64'(i), 0,
                                            $urandom));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_SUBMIT, 16'h3, 64'h9, 16'h33, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_SUBMIT, 16'h3, 64'h8, 16'h34, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_COMPLETION, 16'h3, 64'h1, 0, 32'hDEAD));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_TAKE, 16'h3, 64'h1, 0, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_TAKE, 16'h2, 64'h4, 0, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_SUBMIT, 16'h2, 64'h7, 16'h55, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_REMATCH, 0, 0, 0, 0));
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        hold_send <= 1'b0;
        wait (pending_cmds.size() == 0 && expected_beats.size() == 0);
        // fill the waiter table to capacity, then pause until drained
        hold_send <= 1'b1;
        for (int i = 0; i < WSLOTS + 2; i++)
            pending_cmds.push_back(make_cmd(cwm_pkg::OP_SUBMIT, 16'h1, 64'(i % 4), 16'(i), 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_REMATCH, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(cwm_pkg::OP_COMPACT, 0, 0, 0, 0));
        @(posedge i_clk);
        hold_send <= 1'b0;
        for (int i = 0; i < 30; i++) begin
            pending_cmds.push_back(rand_cmd());
            if (i == 20) calm = 1'b1;
            wait (pending_cmds.size() < 4);
        end
        wait (pending_cmds.size() == 0);
        stim_done = 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (i_valid && o_stall) begin
            // hold the beat
        end else if (send_gap > 0) begin
            i_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (!hold_send && pending_cmds.size() > 0) begin
            t_cmd c;
            c = pending_cmds.pop_front();
            predict_match(c);
            i_valid <= 1'b1;
            i_operation <= c.op;
            i_cq_id <= c.cq;
            i_wr_id <= c.wr;
            i_waiter_tag <= c.tag;
            i_completion_info <= c.info;
            if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver stall and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected result beat, outcome %0d", o_outcome);
                    errors++;
                end else begin
                    t_res e;
                    e = expected_beats.pop_front();
                    if (o_outcome !== e.outcome) begin
                        $error("outcome exp %0d got %0d", e.outcome, o_outcome); errors++;
                    end
                    if (o_out_waiter_tag !== e.tag) begin
                        $error("out_waiter_tag exp %h got %h", e.tag, o_out_waiter_tag);
                        errors++;
                    end
                    if (o_out_wr_id !== e.wr) begin
                        $error("out_wr_id exp %h got %h", e.wr, o_out_wr_id); errors++;
                    end
                    if (o_out_completion !== e.comp) begin
                        $error("out_completion exp %h got %h", e.comp, o_out_completion);
                        errors++;
                    end
                    if (o_overflow_count !== e.ovf) begin
                        $error("overflow_count exp %h got %h", e.ovf, o_overflow_count);
                        errors++;
                    end
                    if (o_last !== e.last) begin
                        $error("last exp %b got %b", e.last, o_last); errors++;
                    end
                end
            end
            if (stall_gap > 0) begin
                stall_gap <= stall_gap - 1;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                stall_gap <= $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_operation = cwm_pkg::OP_COMPACT;
        i_cq_id = '0;
        i_wr_id = '0;
        i_waiter_tag = '0;
        i_completion_info = '0;
    end

    // watchdog and end of run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("completion_waiter_matcher: mismatch");
            $finish;
        end
    end

    initial begin
        wait (stim_done && expected_beats.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("completion_waiter_matcher: match");
        end else begin
            $display("completion_waiter_matcher: mismatch");
        end
        $finish;
    end
endmodule
